// ===== src/mwtg_pkg.sv =====
// Shared definitions for the multi waveform table generator.
// Holds default sizes, register indexes and the noise status struct; no dependencies.
package mwtg_pkg;

  // default number of entries in every waveform table
  localparam int TableLenDef = 256;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgMaxLevel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinLevel = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMidLevel = 2'd2;

  // noise generator seeds
  localparam logic [31:0] XsSeed   = 32'h1234_5678;
  localparam logic [14:0] LfsrSeed = 15'h7FFF;

  // output selection bits of the noise generators for one entry
  typedef struct packed {
    logic white_bit;
    logic long_bit;
    logic short_bit;
  } noise_bits_t;

endpackage

// ===== src/mwtg_cos_rom.sv =====
// Cosine lookup ROM in Q1.16, one entry per table position, registered read.
// Contents are built at elaboration from a fixed-point Taylor series; uses mwtg_pkg.
module mwtg_cos_rom import mwtg_pkg::*; #(
  parameter int NUM_ENTRIES = TableLenDef,
  localparam int PW = $clog2(NUM_ENTRIES)
) (
  input  logic                 clk_i,
  input  logic [PW-1:0]        addr_i,
  output logic signed [17:0]   data_o
);

  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint          OneQ30 = 64'sd1073741824;

  typedef logic signed [17:0] rom_t [NUM_ENTRIES];

  // cosine of 2*pi*p/NUM_ENTRIES, folded to the first quadrant
  function automatic logic signed [17:0] cos_entry(int p);
    int              k;
    logic            neg;
    longint unsigned m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    k   = (p > NUM_ENTRIES - p) ? NUM_ENTRIES - p : p;
    neg = 1'b0;
    if (4 * k > NUM_ENTRIES) begin
      m   = longint'(NUM_ENTRIES - 2 * k);
      neg = 1'b1;
    end else begin
      m = longint'(2 * k);
    end
    x    = (PiQ30 * m) / NUM_ENTRIES;
    x2   = (x * x) >> 30;
    term = longint'(OneQ30);
    sum  = OneQ30;
    term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 306; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 380; sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > OneQ30) begin
      sum = OneQ30;
    end
    sum = (sum + 8192) >>> 14;
    return neg ? 18'(-sum) : 18'(sum);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      r[i] = cos_entry(i);
    end
    return r;
  endfunction

  localparam rom_t CosRom = build_rom();

  // registered read port
  always_ff @(posedge clk_i) begin
    data_o <= CosRom[addr_i];
  end

endmodule

// ===== src/mwtg_prep.sv =====
// Look-ahead stage: products and cosine for the position the next entry will use.
// Registers ramp magnitudes and the ROM word every cycle; uses mwtg_pkg and mwtg_cos_rom.
module mwtg_prep import mwtg_pkg::*; #(
  parameter int NUM_ENTRIES = TableLenDef,
  localparam int PW = $clog2(NUM_ENTRIES),
  localparam int GW = $clog2(NUM_ENTRIES + 1),
  localparam int NW = GW + 16
) (
  input  logic                 clk_i,
  input  logic [PW-1:0]        pos_i,
  input  logic [15:0]          abs_span_i,
  output logic [NW-1:0]        tri_mag_o,
  output logic [NW-1:0]        saw_mag_o,
  output logic signed [17:0]   cos_o
);

  localparam int Half = NUM_ENTRIES / 2;

  logic [GW-1:0] tri_fac;
  logic [GW-1:0] saw_fac;
  logic [NW-1:0] tri_mag_d, saw_mag_d;
  logic [NW-1:0] tri_mag_q, saw_mag_q;

  // distance along the rising or falling ramp
  always_comb begin
    saw_fac = GW'(NUM_ENTRIES) - GW'(pos_i);
    if (pos_i < PW'(Half)) begin
      tri_fac = GW'(pos_i);
    end else begin
      tri_fac = saw_fac;
    end
    tri_mag_d = NW'(tri_fac) * NW'(abs_span_i);
    saw_mag_d = NW'(saw_fac) * NW'(abs_span_i);
  end

  always_ff @(posedge clk_i) begin
    tri_mag_q <= tri_mag_d;
    saw_mag_q <= saw_mag_d;
  end

  assign tri_mag_o = tri_mag_q;
  assign saw_mag_o = saw_mag_q;

  // cosine word for the same position
  mwtg_cos_rom #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_cos_rom (
    .clk_i (clk_i),
    .addr_i(pos_i),
    .data_o(cos_o)
  );

endmodule

// ===== src/mwtg_recip_div.sv =====
// Unsigned division by a fixed divisor through a reciprocal multiply.
// Exact for every N-bit dividend; imports mwtg_pkg for its default sizes.
module mwtg_recip_div import mwtg_pkg::*; #(
  parameter int N = 16 + $clog2(TableLenDef + 1),
  parameter int DIVISOR = TableLenDef
) (
  input  logic [N-1:0] num_i,
  output logic [N-1:0] quo_o
);

  localparam int L = $clog2(DIVISOR);
  localparam int S = N + L;
  localparam longint unsigned Recip = ((64'd1 << S) + DIVISOR - 1) / DIVISOR;
  localparam logic [N:0] RecipC = (N + 1)'(Recip);

  logic [2*N:0] prod;

  // quotient is the top bits of dividend times the rounded-up reciprocal
  assign prod  = {{(N + 1){1'b0}}, num_i} * {{N{1'b0}}, RecipC};
  assign quo_o = N'(prod >> S);

endmodule

// ===== src/mwtg_noise.sv =====
// Noise generators: xorshift32 white noise and the long and short mode LFSRs.
// Advances once per accepted entry and reseeds on restart or table wrap; uses mwtg_pkg.
module mwtg_noise import mwtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        restart_i,
  input  logic        wrap_i,
  output noise_bits_t bits_o
);

  function automatic logic [31:0] xs_step(logic [31:0] s);
    logic [31:0] v;
    v = s ^ (s << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

  function automatic logic [14:0] lfsr_step(logic [14:0] s, logic seven);
    logic        fb;
    logic [14:0] v;
    fb = s[0] ^ s[1];
    v  = {fb, s[14:1]};
    if (seven) begin
      v[6] = fb;
    end
    return v;
  endfunction

  localparam logic [31:0] XsAfterSeed = xs_step(XsSeed);

  logic [31:0] xs_q, xs_eff, xs_new;
  logic [14:0] long_q, long_eff;
  logic [14:0] short_q, short_eff;

  // restart takes the seeds in place of the running state
  always_comb begin
    xs_eff    = restart_i ? XsSeed   : xs_q;
    long_eff  = restart_i ? LfsrSeed : long_q;
    short_eff = restart_i ? LfsrSeed : short_q;
    xs_new    = xs_step(xs_eff);
    bits_o.white_bit = xs_new[0];
    bits_o.long_bit  = long_eff[0];
    bits_o.short_bit = short_eff[0];
  end

  // state update per transfer, reseed after the final entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q    <= XsSeed;
      long_q  <= LfsrSeed;
      short_q <= LfsrSeed;
    end else if (fire_i) begin
      if (wrap_i) begin
        xs_q    <= XsSeed;
        long_q  <= LfsrSeed;
        short_q <= LfsrSeed;
      end else begin
        xs_q    <= xs_new;
        long_q  <= lfsr_step(long_eff, 1'b0);
        short_q <= lfsr_step(short_eff, 1'b1);
      end
    end
  end

  // xorshift and the plain LFSR are invertible, so they never reach zero
  assert property (@(posedge clk_i) disable iff (!rst_ni) xs_q != 32'd0)
    else $error("xorshift state went to zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni) long_q != 15'd0)
    else $error("long lfsr went to zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && restart_i && !wrap_i |=> xs_q == XsAfterSeed)
    else $error("restart did not reseed the xorshift state");

endmodule

// ===== src/multi_waveform_table_generator_unit.sv =====
// Top level of the multi waveform table generator: handshakes, levels, shaping.
// Uses mwtg_pkg, mwtg_prep, mwtg_recip_div and mwtg_noise.
//
//  channel   | direction | signals                         | content
//  ----------+-----------+---------------------------------+-------------------------------
//  s_axis    | in        | tvalid tready tdata[7:0]        | restart
//  m_axis    | out       | tvalid tready tdata[167:0] tlast| index, ten samples, last entry
//  cfg       | in        | valid ready index[1:0] data[15:0]| level registers
//
// One entry per clock unless the output stalls or the look-ahead registers reload; each
// entry is written to the output register on its input transfer, with at most one
// multiplier on each path after the look-ahead products registered in mwtg_prep.
// After reset and after every configuration write, s_axis_tready_o stays low
// while the look-ahead registers reload.
// An output stall holds the result; a new entry is still taken when the result
// register is being emptied in the same cycle.
module multi_waveform_table_generator_unit import mwtg_pkg::*; #(
  parameter int NUM_ENTRIES = TableLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,  // [0] restart, [7:1] zero
  // output stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [7:0] entry_index, [23:8] square_eighth, [39:24] square_quarter,
  // [55:40] square_half, [71:56] square_three_quarter, [87:72] triangle_sample,
  // [103:88] saw_sample, [119:104] white_noise, [135:120] long_noise,
  // [151:136] short_noise, [167:152] cosine_sample
  output logic [167:0]       m_axis_tdata_o,
  output logic               m_axis_tlast_o,   // last_entry
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int PW   = $clog2(NUM_ENTRIES);
  localparam int GW   = $clog2(NUM_ENTRIES + 1);
  localparam int NW   = GW + 16;
  localparam int Half = NUM_ENTRIES / 2;

  // level registers
  logic signed [15:0] max_q, min_q, mid_q;
  logic               cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 16'sd32767;
      min_q <= -16'sd32768;
      mid_q <= 16'sd0;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CfgMaxLevel: max_q <= cfg_data_i;
        CfgMinLevel: min_q <= cfg_data_i;
        CfgMidLevel: mid_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // look-ahead registers valid; cleared on reset and on every configuration write
  logic warm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= 1'b0;
    end else begin
      warm_q <= !cfg_fire;
    end
  end

  // handshake
  logic out_valid_q;
  logic s_fire, m_fire;

  assign s_axis_tready_o = warm_q && (!out_valid_q || m_axis_tready_i);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_fire          = out_valid_q & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // table position
  logic          restart;
  logic [PW-1:0] pos_q, pos_d, pos_eff, pos_next;
  logic          is_last;

  assign restart  = s_axis_tdata_i[0];
  assign pos_eff  = restart ? '0 : pos_q;
  assign is_last  = (pos_eff == PW'(NUM_ENTRIES - 1));
  assign pos_next = is_last ? '0 : pos_eff + PW'(1);
  assign pos_d    = s_fire ? pos_next : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // span and offset of the ramps
  logic signed [16:0] span;
  logic [15:0]        abs_span;
  logic               span_neg;
  logic [15:0]        offset;

  assign span     = 17'(max_q) - 17'(min_q);
  assign span_neg = span[16];
  assign abs_span = span_neg ? 16'(-span) : span[15:0];
  assign offset   = 16'(mid_q) - 16'(min_q);

  // look-ahead products and cosine for the current position
  logic [NW-1:0]      tri_mag, saw_mag;
  logic signed [17:0] cos_word;

  mwtg_prep #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_prep (
    .clk_i     (clk_i),
    .pos_i     (pos_d),
    .abs_span_i(abs_span),
    .tri_mag_o (tri_mag),
    .saw_mag_o (saw_mag),
    .cos_o     (cos_word)
  );

  // ramp divisions
  logic [NW-1:0] tri_quo, saw_quo;

  mwtg_recip_div #(
    .N      (NW),
    .DIVISOR(Half)
  ) u_tri_div (
    .num_i(tri_mag),
    .quo_o(tri_quo)
  );

  mwtg_recip_div #(
    .N      (NW),
    .DIVISOR(NUM_ENTRIES)
  ) u_saw_div (
    .num_i(saw_mag),
    .quo_o(saw_quo)
  );

  // noise
  noise_bits_t noise_bits;

  mwtg_noise u_noise (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s_fire),
    .restart_i(restart),
    .wrap_i   (is_last),
    .bits_o   (noise_bits)
  );

  // sample shaping; a restart lands on position zero with known values
  logic [15:0]        sq_eighth, sq_quarter, sq_half, sq_three;
  logic [15:0]        tri_val, saw_val, tri_smp, saw_smp;
  logic [15:0]        white_smp, long_smp, short_smp, cos_smp;
  logic signed [33:0] cos_prod, cos_adj;

  always_comb begin
    sq_eighth  = (pos_eff < PW'(NUM_ENTRIES / 8))       ? max_q : min_q;
    sq_quarter = (pos_eff < PW'(NUM_ENTRIES / 4))       ? max_q : min_q;
    sq_half    = (pos_eff < PW'(NUM_ENTRIES / 2))       ? max_q : min_q;
    sq_three   = (pos_eff < PW'((NUM_ENTRIES * 3) / 4)) ? max_q : min_q;

    if (restart) begin
      tri_val = 16'd0;
      saw_val = span[15:0];
    end else begin
      tri_val = span_neg ? -tri_quo[15:0] : tri_quo[15:0];
      saw_val = span_neg ? -saw_quo[15:0] : saw_quo[15:0];
    end
    tri_smp = tri_val - offset;
    saw_smp = saw_val - offset;

    white_smp = noise_bits.white_bit ? max_q : min_q;
    long_smp  = noise_bits.long_bit  ? min_q : max_q;
    short_smp = noise_bits.short_bit ? min_q : max_q;

    // truncate toward zero on the divide by 2^16
    cos_prod = max_q * cos_word;
    cos_adj  = cos_prod[33] ? cos_prod + 34'sd65535 : cos_prod;
    cos_smp  = restart ? max_q : cos_adj[31:16];
  end

  // result register
  logic [167:0] out_data_q;
  logic         out_last_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= {cos_smp, short_smp, long_smp, white_smp, saw_smp, tri_smp,
                     sq_three, sq_half, sq_quarter, sq_eighth, 8'(pos_eff)};
      out_last_q <= is_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // no input transfer while look-ahead registers reload after a level write
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_fire |=> !s_axis_tready_o)
    else $error("input taken before look-ahead reload");
  // an accepted entry is offered on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_fire |=> m_axis_tvalid_o)
    else $error("accepted entry not presented");
  // final entry carries the last table index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[7:0] == 8'(NUM_ENTRIES - 1))
    else $error("last flag on wrong entry");
  // position wraps after the final entry
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_fire && is_last |=> pos_q == '0)
    else $error("position did not wrap");

endmodule
